### src/fcdbl_pkg.sv
`default_nettype none

package fcdbl_pkg;

   // payload buffer depth
   localparam int BUFFER_BYTES_DEF = 12;

   // configuration port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;
   localparam int POS_W      = 15;
   localparam int DIM_W      = 5;

   localparam logic [REG_IDX_W-1:0] REG_GRID_DIM = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_X_OFFSET = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_Y_OFFSET = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_X_LAST   = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_Y_LAST   = 3'd4;

   localparam logic [DIM_W-1:0] GRID_DIM_RST = 5'd12;
   localparam logic [POS_W-1:0] X_OFFSET_RST = 15'd10;
   localparam logic [POS_W-1:0] Y_OFFSET_RST = 15'd10;
   localparam logic [POS_W-1:0] X_LAST_RST   = 15'd6085;
   localparam logic [POS_W-1:0] Y_LAST_RST   = 15'd6100;
   localparam logic [DIM_W-1:0] GRID_DIM_MIN = 5'd2;

   // received characters
   localparam logic [7:0] CH_OPEN  = 8'h3C;  // '<'
   localparam logic [7:0] CH_CLOSE = 8'h3E;  // '>'
   localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
   localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_MOVE  = 8'h6D;  // 'm'
   localparam logic [7:0] CH_HALF  = 8'h68;  // 'h'
   localparam logic [7:0] CH_HOME  = 8'h61;  // 'a'
   localparam logic [7:0] CH_BACK  = 8'h62;  // 'b'
   localparam logic [7:0] CH_FWD   = 8'h66;  // 'f'

   // result command codes
   localparam logic [2:0] CMD_MOVE    = 3'd0;
   localparam logic [2:0] CMD_THERE   = 3'd1;
   localparam logic [2:0] CMD_CENTER  = 3'd2;
   localparam logic [2:0] CMD_HOME    = 3'd3;
   localparam logic [2:0] CMD_JOG     = 3'd4;
   localparam logic [2:0] CMD_UNKNOWN = 3'd5;
   localparam logic [2:0] CMD_CKSUM   = 3'd6;
   localparam logic [2:0] CMD_FRAME   = 3'd7;

   localparam logic signed [12:0] JOG_AMOUNT = 13'sd4000;

   // shared divider
   localparam int DIV_BITS  = 15;
   localparam int DIV_CNT_W = $clog2(DIV_BITS);
   localparam int BIN_W     = 10;

   typedef struct packed {
      logic [DIM_W-1:0] grid_dim;
      logic [POS_W-1:0] x_offset;
      logic [POS_W-1:0] y_offset;
      logic [POS_W-1:0] x_last;
      logic [POS_W-1:0] y_last;
   } cfg_type;

   typedef struct packed {
      logic                start;
      logic [DIV_BITS-1:0] dividend;
      logic [DIM_W-1:0]    divisor;
   } div_req_type;

   typedef struct packed {
      logic                done;
      logic [DIV_BITS-1:0] quotient;
      logic [DIM_W-1:0]    remainder;
   } div_rsp_type;

   typedef struct packed {
      logic [2:0]       command;
      logic [BIN_W-1:0] bin_number;
      logic [15:0]      x_target;
      logic [15:0]      y_target;
      logic [12:0]      jog_steps;
   } result_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_PX_START,
      ST_PX_WAIT,
      ST_PY_START,
      ST_PY_WAIT,
      ST_SUM_RD,
      ST_SUM_ACC,
      ST_CK0_RD,
      ST_CK0_USE,
      ST_CK1_RD,
      ST_CK1_USE,
      ST_OP_RD,
      ST_OP_USE,
      ST_NUM_RD,
      ST_NUM_USE,
      ST_CLAMP,
      ST_LOC_START,
      ST_LOC_WAIT,
      ST_MUL_X,
      ST_ADD_X,
      ST_MUL_Y,
      ST_ADD_Y,
      ST_EMIT
   } state_type;

endpackage

`default_nettype wire

### src/framed_command_decoder_bin_locator_core.sv
// Framed command decoder with bin locator.
// The req stream carries one received byte per word in req_tdata. '<' opens a
// frame, '>' closes it; the last two payload bytes are a decimal checksum of
// the earlier bytes mod 100. Each closed frame yields one rsp word (command,
// bin number, x/y step targets, jog amount); all other bytes yield none.
// A byte that does not close a frame is taken while the sequencer is idle
// and no pitch computation is pending. A closing '>' of an open frame holds
// req_tready low while the sequencer walks the payload buffer, then decodes;
// a bin command goes through the shared divider, which yields the bin's
// column and row, plus two multiply-add steps. The same divider computes
// the x and y pitch after reset and after every write to one of the five
// registers (req_tready low meanwhile).
// The result sits in an output register: the next bytes are taken while it
// waits for rsp_tready; only a second frame close waits for it to drain.
// Reset (synchronous) restores the register defaults, drops any open frame,
// clears the current bin and starts the pitch computation.
`default_nettype none

module framed_command_decoder_bin_locator_core
   import fcdbl_pkg::*;
#(
   parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // input byte stream
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [7:0]            req_tdata,   // rx_byte[7:0]
   // result stream
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [63:0]                rsp_tdata,   // command[2:0], bin_number[12:3],
                                                   // x_target[28:13], y_target[44:29],
                                                   // jog_steps[57:45], zero[63:58]
   // configuration
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   cfg_type     cfg;
   logic        cfg_written;
   div_req_type div_req;
   div_rsp_type div_rsp;
   result_type  rsp_word;

   fcdbl_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg),
      .cfg_written (cfg_written)
   );

   fcdbl_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   fcdbl_engine #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .cfg_written (cfg_written),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_byte    (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_word    (rsp_word),
      .div_req     (div_req),
      .div_rsp     (div_rsp)
   );

   // pack the result word, first field in the low bits
   assign rsp_tdata = {6'b000000, rsp_word.jog_steps, rsp_word.y_target,
                       rsp_word.x_target, rsp_word.bin_number, rsp_word.command};

endmodule

`default_nettype wire

### src/fcdbl_div.sv
`default_nettype none

module fcdbl_div
   import fcdbl_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type req,
   output div_rsp_type      rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_BITS-1:0]  dq_ff, dq_in;
   logic [DIM_W-1:0]     rem_ff, rem_in;
   logic [DIM_W-1:0]     dsr_ff, dsr_in;
   logic [DIM_W:0]       trial;
   logic                 fits;

   // one restoring step per cycle, quotient bits shift in behind the dividend
   always_comb begin
      trial   = {rem_ff, dq_ff[DIV_BITS-1]};
      fits    = trial >= {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dq_in   = req.dividend;
         rem_in  = '0;
         dsr_in  = req.divisor;
      end else if (busy_ff) begin
         dq_in  = {dq_ff[DIV_BITS-2:0], fits};
         rem_in = fits ? DIM_W'(trial - {1'b0, dsr_ff}) : trial[DIM_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = dq_ff;
   assign rsp.remainder = rem_ff;

endmodule

`default_nettype wire

### src/fcdbl_csr.sv
`default_nettype none

module fcdbl_csr
   import fcdbl_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready,
   output cfg_type                    cfg,
   output logic                       cfg_written
);

   cfg_type              cfg_ff, cfg_in;
   logic                 wr_en;
   logic [REG_IDX_W-1:0] reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   // register write decode
   always_comb begin
      cfg_in      = cfg_ff;
      cfg_written = 1'b0;
      if (wr_en) begin
         cfg_written = 1'b1;
         case (reg_idx)
            REG_GRID_DIM: cfg_in.grid_dim = csr_pwdata[DIM_W-1:0];
            REG_X_OFFSET: cfg_in.x_offset = csr_pwdata[POS_W-1:0];
            REG_Y_OFFSET: cfg_in.y_offset = csr_pwdata[POS_W-1:0];
            REG_X_LAST:   cfg_in.x_last   = csr_pwdata[POS_W-1:0];
            REG_Y_LAST:   cfg_in.y_last   = csr_pwdata[POS_W-1:0];
            default:      cfg_written     = 1'b0;
         endcase
      end
   end

   // register read mux
   always_comb begin
      case (reg_idx)
         REG_GRID_DIM: csr_prdata = CSR_DATA_W'(cfg_ff.grid_dim);
         REG_X_OFFSET: csr_prdata = CSR_DATA_W'(cfg_ff.x_offset);
         REG_Y_OFFSET: csr_prdata = CSR_DATA_W'(cfg_ff.y_offset);
         REG_X_LAST:   csr_prdata = CSR_DATA_W'(cfg_ff.x_last);
         REG_Y_LAST:   csr_prdata = CSR_DATA_W'(cfg_ff.y_last);
         default:      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.grid_dim <= GRID_DIM_RST;
         cfg_ff.x_offset <= X_OFFSET_RST;
         cfg_ff.y_offset <= Y_OFFSET_RST;
         cfg_ff.x_last   <= X_LAST_RST;
         cfg_ff.y_last   <= Y_LAST_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

### src/fcdbl_engine.sv
`default_nettype none

module fcdbl_engine
   import fcdbl_pkg::*;
#(
   parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cfg_type     cfg,
   input  wire logic        cfg_written,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_byte,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output result_type       rsp_word,
   output div_req_type      div_req,
   input  wire div_rsp_type div_rsp
);

   localparam int IDX_W  = $clog2(BUFFER_BYTES);
   localparam int FILL_W = $clog2(BUFFER_BYTES + 1);

   state_type         state_ff, state_in;
   logic [7:0]        payload_ff [BUFFER_BYTES];
   logic [7:0]        rd_data_ff;
   logic              capturing_ff, capturing_in;
   logic              overflowed_ff, overflowed_in;
   logic              pend_ff, pend_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [FILL_W-1:0] len_ff, len_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [6:0]        acc_ff, acc_in;
   logic signed [8:0] d1_ff, d1_in;
   logic [1:0]        avail_ff, avail_in;
   logic              neg_ff, neg_in;
   logic              digits_ff, digits_in;
   logic [BIN_W-1:0]  num_ff, num_in;
   logic [BIN_W-1:0]  bin_ff, bin_in;
   logic [BIN_W-1:0]  cur_bin_ff, cur_bin_in;
   logic              center_ff, center_in;
   logic              neg_pitch_ff, neg_pitch_in;
   logic [DIM_W-1:0]  col_ff, col_in;
   logic [DIM_W-1:0]  row_ff, row_in;
   logic [15:0]       prod_ff, prod_in;
   logic [15:0]       xt_ff, xt_in;
   logic [15:0]       xp_ff, xp_in;
   logic [15:0]       yp_ff, yp_in;
   result_type        res_ff, res_in;
   result_type        out_ff, out_in;
   logic              out_valid_ff, out_valid_in;

   logic              req_fire;
   logic              wr_en;
   logic [DIM_W-1:0]  dim;
   logic [BIN_W-1:0]  dim_sq;
   logic [BIN_W-1:0]  center_bin;
   logic signed [15:0] x_diff;
   logic signed [15:0] y_diff;
   logic [8:0]        sum_raw;
   logic [6:0]        sum_mod;
   logic signed [8:0] d0;
   logic signed [12:0] rx_value;
   logic [FILL_W-1:0] len_m1;
   logic              is_digit;
   logic              is_space;
   logic [BIN_W-1:0]  num_next;
   logic [BIN_W-1:0]  clamped;
   logic [15:0]       quot_signed;

   // grid geometry from the registers
   always_comb begin
      dim        = (cfg.grid_dim < GRID_DIM_MIN) ? GRID_DIM_MIN : cfg.grid_dim;
      dim_sq     = BIN_W'(dim * dim);
      center_bin = (dim_sq >> 1) - BIN_W'(dim >> 1);
      x_diff     = $signed({1'b0, cfg.x_last}) - $signed({1'b0, cfg.x_offset});
      y_diff     = $signed({1'b0, cfg.y_last}) - $signed({1'b0, cfg.y_offset});
   end

   // byte classification and small datapath pieces
   always_comb begin
      sum_raw = {2'b00, acc_ff} + {1'b0, rd_data_ff};
      if (sum_raw >= 9'd300) begin
         sum_mod = 7'(sum_raw - 9'd300);
      end else if (sum_raw >= 9'd200) begin
         sum_mod = 7'(sum_raw - 9'd200);
      end else if (sum_raw >= 9'd100) begin
         sum_mod = 7'(sum_raw - 9'd100);
      end else begin
         sum_mod = sum_raw[6:0];
      end
      d0       = $signed({1'b0, rd_data_ff}) - $signed({1'b0, CH_ZERO});
      rx_value = $signed({{4{d1_ff[8]}}, d1_ff}) * 13'sd10 + $signed({{4{d0[8]}}, d0});
      len_m1   = len_ff - 1'b1;
      is_digit = (rd_data_ff >= CH_ZERO) && (rd_data_ff <= CH_NINE);
      is_space = (rd_data_ff == CH_SPACE) ||
                 ((rd_data_ff >= CH_TAB) && (rd_data_ff <= CH_CR));
      num_next = BIN_W'((num_ff << 3) + (num_ff << 1)) + BIN_W'(rd_data_ff - CH_ZERO);
      if (neg_ff || (num_ff == '0)) begin
         clamped = BIN_W'(1);
      end else if (num_ff > dim_sq) begin
         clamped = dim_sq;
      end else begin
         clamped = num_ff;
      end
      quot_signed = neg_pitch_ff ? 16'(-{1'b0, div_rsp.quotient}) : {1'b0, div_rsp.quotient};
   end

   assign req_tready = (state_ff == ST_IDLE) && !pend_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign wr_en      = req_fire && capturing_ff && (req_byte != CH_OPEN) &&
                       (req_byte != CH_CLOSE) && (fill_ff < FILL_W'(BUFFER_BYTES));

   // sequencer
   always_comb begin
      state_in      = state_ff;
      capturing_in  = capturing_ff;
      overflowed_in = overflowed_ff;
      pend_in       = pend_ff;
      fill_in       = fill_ff;
      len_in        = len_ff;
      idx_in        = idx_ff;
      acc_in        = acc_ff;
      d1_in         = d1_ff;
      avail_in      = avail_ff;
      neg_in        = neg_ff;
      digits_in     = digits_ff;
      num_in        = num_ff;
      bin_in        = bin_ff;
      cur_bin_in    = cur_bin_ff;
      center_in     = center_ff;
      neg_pitch_in  = neg_pitch_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      prod_in       = prod_ff;
      xt_in         = xt_ff;
      xp_in         = xp_ff;
      yp_in         = yp_ff;
      res_in        = res_ff;
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      div_req       = '0;

      // output register drains independently
      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (pend_ff) begin
               state_in = ST_PX_START;
            end else if (req_fire) begin
               if (req_byte == CH_OPEN) begin
                  capturing_in  = 1'b1;
                  fill_in       = '0;
                  overflowed_in = 1'b0;
               end else if (req_byte != CH_CLOSE) begin
                  if (capturing_ff) begin
                     if (fill_ff < FILL_W'(BUFFER_BYTES)) begin
                        fill_in = fill_ff + 1'b1;
                     end else begin
                        overflowed_in = 1'b1;
                     end
                  end
               end else if (capturing_ff) begin
                  capturing_in = 1'b0;
                  if (overflowed_ff || (fill_ff < FILL_W'(2))) begin
                     res_in         = '0;
                     res_in.command = CMD_FRAME;
                     state_in       = ST_EMIT;
                  end else begin
                     len_in = fill_ff - FILL_W'(2);
                     acc_in = '0;
                     if (fill_ff == FILL_W'(2)) begin
                        idx_in   = '0;
                        state_in = ST_CK0_RD;
                     end else begin
                        idx_in   = '0;
                        state_in = ST_SUM_RD;
                     end
                  end
               end
            end
         end

         // pitch = (last - offset) / (dim - 1), truncated toward zero
         ST_PX_START: begin
            pend_in          = 1'b0;
            neg_pitch_in     = x_diff[15];
            div_req.start    = 1'b1;
            div_req.dividend = x_diff[15] ? DIV_BITS'(-x_diff) : x_diff[DIV_BITS-1:0];
            div_req.divisor  = dim - 1'b1;
            state_in         = ST_PX_WAIT;
         end
         ST_PX_WAIT: begin
            if (div_rsp.done) begin
               xp_in    = quot_signed;
               state_in = ST_PY_START;
            end
         end
         ST_PY_START: begin
            neg_pitch_in     = y_diff[15];
            div_req.start    = 1'b1;
            div_req.dividend = y_diff[15] ? DIV_BITS'(-y_diff) : y_diff[DIV_BITS-1:0];
            div_req.divisor  = dim - 1'b1;
            state_in         = ST_PY_WAIT;
         end
         ST_PY_WAIT: begin
            if (div_rsp.done) begin
               yp_in    = quot_signed;
               state_in = ST_IDLE;
            end
         end

         // running sum of the message bytes mod 100
         ST_SUM_RD: begin
            state_in = ST_SUM_ACC;
         end
         ST_SUM_ACC: begin
            acc_in = sum_mod;
            if ((FILL_W'(idx_ff) + 1'b1) == len_ff) begin
               idx_in   = len_ff[IDX_W-1:0];
               state_in = ST_CK0_RD;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_SUM_RD;
            end
         end

         // two checksum digits
         ST_CK0_RD: begin
            state_in = ST_CK0_USE;
         end
         ST_CK0_USE: begin
            d1_in    = d0;
            idx_in   = idx_ff + 1'b1;
            state_in = ST_CK1_RD;
         end
         ST_CK1_RD: begin
            state_in = ST_CK1_USE;
         end
         ST_CK1_USE: begin
            res_in = '0;
            if (rx_value != $signed({6'b000000, acc_ff})) begin
               res_in.command = CMD_CKSUM;
               state_in       = ST_EMIT;
            end else if (len_ff == '0) begin
               res_in.command = CMD_UNKNOWN;
               state_in       = ST_EMIT;
            end else begin
               idx_in   = '0;
               state_in = ST_OP_RD;
            end
         end

         // opcode byte
         ST_OP_RD: begin
            state_in = ST_OP_USE;
         end
         ST_OP_USE: begin
            res_in = '0;
            case (rd_data_ff)
               CH_MOVE: begin
                  avail_in  = (len_m1 > FILL_W'(3)) ? 2'd3 : len_m1[1:0];
                  num_in    = '0;
                  neg_in    = 1'b0;
                  digits_in = 1'b0;
                  idx_in    = IDX_W'(1);
                  state_in  = (len_m1 == '0) ? ST_CLAMP : ST_NUM_RD;
               end
               CH_HALF: begin
                  bin_in    = center_bin;
                  center_in = 1'b1;
                  state_in  = ST_LOC_START;
               end
               CH_HOME: begin
                  res_in.command = CMD_HOME;
                  state_in       = ST_EMIT;
               end
               CH_BACK: begin
                  res_in.command   = CMD_JOG;
                  res_in.jog_steps = -JOG_AMOUNT;
                  state_in         = ST_EMIT;
               end
               CH_FWD: begin
                  res_in.command   = CMD_JOG;
                  res_in.jog_steps = JOG_AMOUNT;
                  state_in         = ST_EMIT;
               end
               default: begin
                  res_in.command = CMD_UNKNOWN;
                  state_in       = ST_EMIT;
               end
            endcase
         end

         // bin digits: blanks, one sign, then digits
         ST_NUM_RD: begin
            state_in = ST_NUM_USE;
         end
         ST_NUM_USE: begin
            state_in = (idx_ff == IDX_W'(avail_ff)) ? ST_CLAMP : ST_NUM_RD;
            idx_in   = idx_ff + 1'b1;
            if (!digits_ff && is_space) begin
               digits_in = 1'b0;
            end else if (!digits_ff &&
                         ((rd_data_ff == CH_PLUS) || (rd_data_ff == CH_MINUS))) begin
               neg_in    = rd_data_ff == CH_MINUS;
               digits_in = 1'b1;
            end else if (is_digit) begin
               num_in    = num_next;
               digits_in = 1'b1;
            end else begin
               state_in = ST_CLAMP;
            end
         end

         ST_CLAMP: begin
            res_in = '0;
            if (clamped == cur_bin_ff) begin
               res_in.command    = CMD_THERE;
               res_in.bin_number = clamped;
               state_in          = ST_EMIT;
            end else begin
               cur_bin_in = clamped;
               bin_in     = clamped;
               center_in  = 1'b0;
               state_in   = ST_LOC_START;
            end
         end

         // column and row of the bin through the shared divider
         ST_LOC_START: begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_BITS'(bin_ff - 1'b1);
            div_req.divisor  = dim;
            state_in         = ST_LOC_WAIT;
         end
         ST_LOC_WAIT: begin
            if (div_rsp.done) begin
               col_in   = div_rsp.remainder;
               row_in   = div_rsp.quotient[DIM_W-1:0];
               state_in = ST_MUL_X;
            end
         end
         ST_MUL_X: begin
            prod_in  = 16'(xp_ff * {11'b0, col_ff});
            state_in = ST_ADD_X;
         end
         ST_ADD_X: begin
            xt_in    = prod_ff + {1'b0, cfg.x_offset};
            state_in = ST_MUL_Y;
         end
         ST_MUL_Y: begin
            prod_in  = 16'(yp_ff * {11'b0, row_ff});
            state_in = ST_ADD_Y;
         end
         ST_ADD_Y: begin
            res_in            = '0;
            res_in.command    = center_ff ? CMD_CENTER : CMD_MOVE;
            res_in.bin_number = bin_ff;
            res_in.x_target   = xt_ff;
            res_in.y_target   = prod_ff + {1'b0, cfg.y_offset};
            state_in          = ST_EMIT;
         end

         // hand the result to the output register
         ST_EMIT: begin
            if (!out_valid_ff || rsp_tready) begin
               out_in       = res_ff;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cfg_written) begin
         pend_in = 1'b1;
      end
   end

   // payload buffer
   always_ff @(posedge clock) begin
      if (wr_en) begin
         payload_ff[fill_ff[IDX_W-1:0]] <= req_byte;
      end
      rd_data_ff <= payload_ff[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         capturing_ff  <= 1'b0;
         overflowed_ff <= 1'b0;
         pend_ff       <= 1'b1;
         fill_ff       <= '0;
         cur_bin_ff    <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         capturing_ff  <= capturing_in;
         overflowed_ff <= overflowed_in;
         pend_ff       <= pend_in;
         fill_ff       <= fill_in;
         cur_bin_ff    <= cur_bin_in;
         out_valid_ff  <= out_valid_in;
      end
      len_ff       <= len_in;
      idx_ff       <= idx_in;
      acc_ff       <= acc_in;
      d1_ff        <= d1_in;
      avail_ff     <= avail_in;
      neg_ff       <= neg_in;
      digits_ff    <= digits_in;
      num_ff       <= num_in;
      bin_ff       <= bin_in;
      center_ff    <= center_in;
      neg_pitch_ff <= neg_pitch_in;
      col_ff       <= col_in;
      row_ff       <= row_in;
      prod_ff      <= prod_in;
      xt_ff        <= xt_in;
      xp_ff        <= xp_in;
      yp_ff        <= yp_in;
      res_ff       <= res_in;
      out_ff       <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_word   = out_ff;

endmodule

`default_nettype wire
